// ===== rtl/lpp_pkg.sv =====
// Shared types and constants for the lidar point projection unit.
// No dependencies; every other file imports this package.
`default_nettype none
package lpp_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   // register map
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_U    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_V    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FORWARD = 3'd7;

   localparam logic signed [12:0] SHIFT_X_RST = -13'sd203;
   localparam logic signed [12:0] SHIFT_Y_RST = 13'sd41;
   localparam logic signed [12:0] SHIFT_Z_RST = 13'sd166;
   localparam logic [15:0] FOCAL_X_RST  = 16'd11515;
   localparam logic [15:0] FOCAL_Y_RST  = 16'd11570;
   localparam logic [15:0] CENTER_U_RST = 16'd5379;
   localparam logic [15:0] CENTER_V_RST = 16'd3452;
   localparam logic [14:0] MAX_FWD_RST  = 15'd25600;

   // filter limits and color reference, 1/1024 m
   localparam int LIMIT_Y = 6144;
   localparam int LIMIT_Z = -1433;
   localparam int TEN_M   = 10240;
   // n/10 == (n*RECIP_10) >> RECIP_SH for n < 43690
   localparam int RECIP_10 = 52429;
   localparam int RECIP_SH = 19;

   localparam int DIV_W = 21;   // 16 * depth, depth < 2^17
   localparam int Q_W   = 12;   // quotient bits, top one flags saturation

   localparam logic signed [Q_W-1:0] PIX_MIN = -12'sd2048;
   localparam logic signed [Q_W-1:0] PIX_MAX = 12'sd2047;

   typedef struct packed {
      logic       valid;
      logic       accepted;
      logic       neg_u;
      logic       neg_v;
      logic [7:0] red;
      logic [7:0] green;
   } ctl_type;

endpackage
`default_nettype wire

// ===== rtl/lpp_front.sv =====
// Front end: filters, frame shift, products, magnitude and color (3 stages).
// Depends on lpp_pkg.
`default_nettype none
module lpp_front #(
   parameter int COORD_WIDTH = lpp_pkg::COORD_WIDTH_DEF,
   parameter int NUM_W = 36
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] point_x,
   input  wire logic signed [COORD_WIDTH-1:0] point_y,
   input  wire logic signed [COORD_WIDTH-1:0] point_z,
   input  wire logic signed [12:0]            shift_x,
   input  wire logic signed [12:0]            shift_y,
   input  wire logic signed [12:0]            shift_z,
   input  wire logic [15:0]                   focal_x,
   input  wire logic [15:0]                   focal_y,
   input  wire logic [15:0]                   center_u,
   input  wire logic [15:0]                   center_v,
   input  wire logic [14:0]                   max_forward,
   output lpp_pkg::ctl_type                   ctl,
   output logic [NUM_W-1:0]                   mag_u,
   output logic [NUM_W-1:0]                   mag_v,
   output logic [lpp_pkg::DIV_W-1:0]          divisor
);
   import lpp_pkg::*;

   localparam int EW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;
   localparam int PW = EW + 17;

   localparam logic signed [EW-1:0] LIM_Y_POS = EW'(LIMIT_Y);
   localparam logic signed [EW-1:0] LIM_Y_NEG = -EW'(LIMIT_Y);
   localparam logic signed [EW-1:0] LIM_Z     = EW'(LIMIT_Z);
   localparam logic signed [EW-1:0] TEN_E     = EW'(TEN_M);

   // stage 1
   logic signed [EW-1:0] xe, ye, ze, sxe, sye, sze, mfe, depth_w, dx_w, ad_w;
   logic                 acc_w;
   logic v1_ff, acc1_ff;
   logic [16:0] depth1_ff;
   logic signed [EW-1:0] latu1_ff, latv1_ff;
   logic [14:0] d1_ff;

   assign xe  = {{(EW-COORD_WIDTH){point_x[COORD_WIDTH-1]}}, point_x};
   assign ye  = {{(EW-COORD_WIDTH){point_y[COORD_WIDTH-1]}}, point_y};
   assign ze  = {{(EW-COORD_WIDTH){point_z[COORD_WIDTH-1]}}, point_z};
   assign sxe = {{(EW-13){shift_x[12]}}, shift_x};
   assign sye = {{(EW-13){shift_y[12]}}, shift_y};
   assign sze = {{(EW-13){shift_z[12]}}, shift_z};
   assign mfe = {{(EW-15){1'b0}}, max_forward};
   assign depth_w = xe + sxe;
   assign dx_w = xe - TEN_E;
   assign ad_w = dx_w[EW-1] ? -dx_w : dx_w;
   assign acc_w = !xe[EW-1] && !(xe > mfe) && !(ye > LIM_Y_POS) && !(ye < LIM_Y_NEG)
                  && !(ze < LIM_Z) && !depth_w[EW-1] && (depth_w != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         acc1_ff   <= acc_w;
         depth1_ff <= depth_w[16:0];
         latu1_ff  <= -(ye + sye);
         latv1_ff  <= -(ze + sze);
         d1_ff     <= ad_w[14:0];
      end
   end

   // stage 2: products
   logic v2_ff, acc2_ff;
   logic [32:0] pcu2_ff, pcv2_ff;
   logic signed [PW-1:0] pfu2_ff, pfv2_ff;
   logic [12:0] nr2_ff, ng2_ff;
   logic [DIV_W-1:0] div2_ff;
   logic [14:0] tm_w;
   logic [22:0] nr_full_w, ng_full_w;

   assign tm_w = 15'(TEN_M) - d1_ff;
   assign nr_full_w = 23'(d1_ff) * 23'd255;
   assign ng_full_w = 23'(tm_w) * 23'd255;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         acc2_ff <= acc1_ff;
         pcu2_ff <= 33'(center_u) * 33'(depth1_ff);
         pcv2_ff <= 33'(center_v) * 33'(depth1_ff);
         pfu2_ff <= $signed({1'b0, focal_x}) * latu1_ff;
         pfv2_ff <= $signed({1'b0, focal_y}) * latv1_ff;
         nr2_ff  <= nr_full_w[22:10];
         ng2_ff  <= (d1_ff < 15'(TEN_M)) ? ng_full_w[22:10] : 13'd0;
         div2_ff <= {depth1_ff, 4'b0000};
      end
   end

   // stage 3: numerator sign and magnitude, color divide by ten
   logic signed [NUM_W-1:0] numu_w, numv_w;
   logic [29:0] rr_w, gg_w;
   logic v3_ff, acc3_ff, negu3_ff, negv3_ff;
   logic [NUM_W-1:0] magu3_ff, magv3_ff;
   logic [DIV_W-1:0] div3_ff;
   logic [7:0] red3_ff, green3_ff;

   assign numu_w = NUM_W'(pfu2_ff) + $signed({{(NUM_W-33){1'b0}}, pcu2_ff});
   assign numv_w = NUM_W'(pfv2_ff) + $signed({{(NUM_W-33){1'b0}}, pcv2_ff});
   assign rr_w = (30'(nr2_ff) * 30'(RECIP_10)) >> RECIP_SH;
   assign gg_w = (30'(ng2_ff) * 30'(RECIP_10)) >> RECIP_SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         acc3_ff   <= acc2_ff;
         negu3_ff  <= numu_w[NUM_W-1];
         negv3_ff  <= numv_w[NUM_W-1];
         magu3_ff  <= numu_w[NUM_W-1] ? NUM_W'(-numu_w) : NUM_W'(numu_w);
         magv3_ff  <= numv_w[NUM_W-1] ? NUM_W'(-numv_w) : NUM_W'(numv_w);
         div3_ff   <= div2_ff;
         red3_ff   <= (rr_w > 30'd255) ? 8'd255 : rr_w[7:0];
         green3_ff <= gg_w[7:0];
      end
   end

   assign ctl = '{valid: v3_ff, accepted: acc3_ff, neg_u: negu3_ff, neg_v: negv3_ff,
                  red: red3_ff, green: green3_ff};
   assign mag_u = magu3_ff;
   assign mag_v = magv3_ff;
   assign divisor = div3_ff;

endmodule
`default_nettype wire

// ===== rtl/lpp_div_cell.sv =====
// One restoring-division cell: decides one quotient bit for both axes.
// Depends on lpp_pkg.
`default_nettype none
module lpp_div_cell #(
   parameter int NUM_W = 36,
   parameter int SHIFT = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire lpp_pkg::ctl_type           up_ctl,
   input  wire logic [NUM_W-1:0]           up_rem_u,
   input  wire logic [NUM_W-1:0]           up_rem_v,
   input  wire logic [lpp_pkg::DIV_W-1:0]  up_div,
   input  wire logic [lpp_pkg::Q_W-1:0]    up_q_u,
   input  wire logic [lpp_pkg::Q_W-1:0]    up_q_v,
   output lpp_pkg::ctl_type                dn_ctl,
   output logic [NUM_W-1:0]                dn_rem_u,
   output logic [NUM_W-1:0]                dn_rem_v,
   output logic [lpp_pkg::DIV_W-1:0]       dn_div,
   output logic [lpp_pkg::Q_W-1:0]         dn_q_u,
   output logic [lpp_pkg::Q_W-1:0]         dn_q_v
);
   import lpp_pkg::*;

   logic [NUM_W-1:0] trial_w;
   logic ge_u, ge_v;
   logic valid_ff;
   ctl_type ctl_ff;
   logic [NUM_W-1:0] rem_u_ff, rem_v_ff;
   logic [DIV_W-1:0] div_ff;
   logic [Q_W-1:0] q_u_ff, q_v_ff, bit_w;

   assign trial_w = {{(NUM_W-DIV_W){1'b0}}, up_div} << SHIFT;
   assign ge_u = up_rem_u >= trial_w;
   assign ge_v = up_rem_v >= trial_w;
   assign bit_w = Q_W'(1) << SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_ctl.valid;
      end
      if (advance) begin
         ctl_ff   <= up_ctl;
         rem_u_ff <= ge_u ? up_rem_u - trial_w : up_rem_u;
         rem_v_ff <= ge_v ? up_rem_v - trial_w : up_rem_v;
         div_ff   <= up_div;
         q_u_ff   <= ge_u ? (up_q_u | bit_w) : up_q_u;
         q_v_ff   <= ge_v ? (up_q_v | bit_w) : up_q_v;
      end
   end

   always_comb begin
      dn_ctl = ctl_ff;
      dn_ctl.valid = valid_ff;
   end
   assign dn_rem_u = rem_u_ff;
   assign dn_rem_v = rem_v_ff;
   assign dn_div = div_ff;
   assign dn_q_u = q_u_ff;
   assign dn_q_v = q_v_ff;

endmodule
`default_nettype wire

// ===== rtl/lidar_point_to_pixel_projection_unit.sv =====
// Top level of the lidar point to pixel projection unit.
// Depends on lpp_pkg, lpp_front and lpp_div_cell.
`default_nettype none
// Projects one lidar point (x forward, y left, z up, 1/1024 m) per beat onto
// the camera image. Points behind the sensor, beyond max_forward, more than
// 6 m sideways, below -1.4 m or with non-positive camera depth come out with
// accepted low and all other fields zero. Accepted points get a pixel
// truncated toward zero and saturated to -2048..2047, plus a red/green color
// from the distance to 10 m. One beat is taken per cycle while the pipe is not
// held. The pipe is 3 front stages (filter/shift, products, magnitude), a
// chain of 12 division cells that each settle one quotient bit for both axes
// against the shared divisor 16*depth (the first cell flags saturation), and
// an output register. The whole pipe holds when the output register is full
// and not taken. Configuration is written through csr_we/csr_index/csr_wdata;
// the user must do so only while the unit is idle; the block does not enforce it.
module lidar_point_to_pixel_projection_unit #(
   parameter int COORD_WIDTH = lpp_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]    req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0]    req_point_y,
   input  wire logic signed [COORD_WIDTH-1:0]    req_point_z,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_accepted,
   output logic signed [11:0]                    rsp_pixel_u,
   output logic signed [11:0]                    rsp_pixel_v,
   output logic [7:0]                            rsp_red,
   output logic [7:0]                            rsp_green,
   input  wire logic                             csr_we,
   input  wire logic [lpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lpp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lpp_pkg::*;

   localparam int EW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;
   localparam int NUM_W = EW + 18;

   // configuration registers
   logic signed [12:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic [15:0] focal_x_ff, focal_y_ff, center_u_ff, center_v_ff;
   logic [14:0] max_fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff  <= SHIFT_X_RST;
         shift_y_ff  <= SHIFT_Y_RST;
         shift_z_ff  <= SHIFT_Z_RST;
         focal_x_ff  <= FOCAL_X_RST;
         focal_y_ff  <= FOCAL_Y_RST;
         center_u_ff <= CENTER_U_RST;
         center_v_ff <= CENTER_V_RST;
         max_fwd_ff  <= MAX_FWD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHIFT_X:     shift_x_ff  <= csr_wdata[12:0];
            CSR_SHIFT_Y:     shift_y_ff  <= csr_wdata[12:0];
            CSR_SHIFT_Z:     shift_z_ff  <= csr_wdata[12:0];
            CSR_FOCAL_X:     focal_x_ff  <= csr_wdata;
            CSR_FOCAL_Y:     focal_y_ff  <= csr_wdata;
            CSR_CENTER_U:    center_u_ff <= csr_wdata;
            CSR_CENTER_V:    center_v_ff <= csr_wdata;
            CSR_MAX_FORWARD: max_fwd_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // global pipe enable: move whenever the output slot is free or drained
   logic advance;
   logic out_v_ff;
   assign advance = !out_v_ff || rsp_ready;
   assign req_ready = advance;

   ctl_type          ctl_w   [0:Q_W];
   logic [NUM_W-1:0] rem_u_w [0:Q_W];
   logic [NUM_W-1:0] rem_v_w [0:Q_W];
   logic [DIV_W-1:0] div_w   [0:Q_W];
   logic [Q_W-1:0]   q_u_w   [0:Q_W];
   logic [Q_W-1:0]   q_v_w   [0:Q_W];

   lpp_front #(.COORD_WIDTH(COORD_WIDTH), .NUM_W(NUM_W)) u_front (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_valid),
      .point_x(req_point_x), .point_y(req_point_y), .point_z(req_point_z),
      .shift_x(shift_x_ff), .shift_y(shift_y_ff), .shift_z(shift_z_ff),
      .focal_x(focal_x_ff), .focal_y(focal_y_ff),
      .center_u(center_u_ff), .center_v(center_v_ff), .max_forward(max_fwd_ff),
      .ctl(ctl_w[0]), .mag_u(rem_u_w[0]), .mag_v(rem_v_w[0]), .divisor(div_w[0])
   );
   assign q_u_w[0] = '0;
   assign q_v_w[0] = '0;

   // division chain, most significant quotient bit first
   for (genvar k = 0; k < Q_W; k++) begin : g_cell
      lpp_div_cell #(.NUM_W(NUM_W), .SHIFT(Q_W - 1 - k)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .up_ctl(ctl_w[k]), .up_rem_u(rem_u_w[k]), .up_rem_v(rem_v_w[k]),
         .up_div(div_w[k]), .up_q_u(q_u_w[k]), .up_q_v(q_v_w[k]),
         .dn_ctl(ctl_w[k+1]), .dn_rem_u(rem_u_w[k+1]), .dn_rem_v(rem_v_w[k+1]),
         .dn_div(div_w[k+1]), .dn_q_u(q_u_w[k+1]), .dn_q_v(q_v_w[k+1])
      );
   end

   // sign, saturation and reject zeroing
   function automatic logic [Q_W-1:0] pix_fix(input logic [Q_W-1:0] q, input logic neg);
      logic [Q_W-1:0] mag;
      mag = {1'b0, q[Q_W-2:0]};
      if (q[Q_W-1]) begin
         pix_fix = neg ? PIX_MIN : PIX_MAX;
      end else begin
         pix_fix = neg ? -mag : mag;
      end
   endfunction

   ctl_type tail_w;
   logic acc_ff;
   logic [11:0] pu_ff, pv_ff;
   logic [7:0] red_ff, green_ff;
   assign tail_w = ctl_w[Q_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= tail_w.valid;
      end
      if (advance) begin
         acc_ff   <= tail_w.accepted;
         pu_ff    <= tail_w.accepted ? pix_fix(q_u_w[Q_W], tail_w.neg_u) : 12'd0;
         pv_ff    <= tail_w.accepted ? pix_fix(q_v_w[Q_W], tail_w.neg_v) : 12'd0;
         red_ff   <= tail_w.accepted ? tail_w.red : 8'd0;
         green_ff <= tail_w.accepted ? tail_w.green : 8'd0;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_pixel_u  = pu_ff;
   assign rsp_pixel_v  = pv_ff;
   assign rsp_red      = red_ff;
   assign rsp_green    = green_ff;

`ifndef NO_ASSERTIONS
   // a rejected point carries no pixel and no color
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |->
         rsp_pixel_u == 12'd0 && rsp_pixel_v == 12'd0 && rsp_red == 8'd0
         && rsp_green == 8'd0)
      else $error("rejected beat with nonzero payload");

   // the two color ramps split at most full scale
   a_color_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> ({1'b0, rsp_red} + {1'b0, rsp_green}) <= 9'd255)
      else $error("red plus green above full scale");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_lidar_point_to_pixel_projection_unit.sv =====
// Testbench for lidar_point_to_pixel_projection_unit: directed table, then random points.
// Depends on lpp_pkg and the unit; results are checked against an in-bench projector.
`default_nettype none
module tb_lidar_point_to_pixel_projection_unit;
   import lpp_pkg::*;

   localparam int CW = 16;
   localparam int LATENCY = 16;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic              accepted;
      logic signed [11:0] pixel_u;
      logic signed [11:0] pixel_v;
      logic [7:0]        red;
      logic [7:0]        green;
   } pixel_type;

   typedef struct {
      logic signed [CW-1:0] x, y, z;
      logic                 known;   // expected result typed in below
      pixel_type            res;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_we = 0;
   logic signed [CW-1:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SHIFT_X;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;
   wire req_ready, rsp_valid, rsp_accepted;
   wire signed [11:0] rsp_pixel_u, rsp_pixel_v;
   wire [7:0] rsp_red, rsp_green;

   lidar_point_to_pixel_projection_unit #(.COORD_WIDTH(CW)) uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // local copy of the camera setup
   longint sh_x, sh_y, sh_z, fc_x, fc_y, ct_u, ct_v, max_fwd;
   pixel_type pixel_queue[$];
   int errors = 0;
   longint cycles = 0;
   int hold_off = 0;   // receiver long stall, cycles left

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic longint pixel_of(longint c, longint f, longint lat, longint dep);
      longint q;
      q = (c * dep + f * lat) / (16 * dep);
      if (q < -2048) q = -2048;
      if (q > 2047) q = 2047;
      return q;
   endfunction

   function automatic pixel_type project_point(logic signed [CW-1:0] px, py, pz);
      pixel_type r;
      longint x, y, z, dep, d, red, grn;
      r = '0;
      x = px; y = py; z = pz;
      if (x < 0 || x > max_fwd || y > LIMIT_Y || y < -LIMIT_Y || z < LIMIT_Z) return r;
      dep = x + sh_x;
      if (dep <= 0) return r;
      d = (x > TEN_M) ? x - TEN_M : TEN_M - x;
      red = (255 * d) / TEN_M;
      if (red > 255) red = 255;
      grn = (255 * (TEN_M - d)) / TEN_M;
      if (grn < 0) grn = 0;
      r.accepted = 1;
      r.pixel_u = 12'(pixel_of(ct_u, fc_x, -(y + sh_y), dep));
      r.pixel_v = 12'(pixel_of(ct_v, fc_y, -(z + sh_z), dep));
      r.red = 8'(red);
      r.green = 8'(grn);
      return r;
   endfunction

   function automatic void setup_reset();
      sh_x = -203; sh_y = 41; sh_z = 166; fc_x = 11515; fc_y = 11570;
      ct_u = 5379; ct_v = 3452; max_fwd = 25600;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_SHIFT_X:     sh_x = $signed(val[12:0]);
         CSR_SHIFT_Y:     sh_y = $signed(val[12:0]);
         CSR_SHIFT_Z:     sh_z = $signed(val[12:0]);
         CSR_FOCAL_X:     fc_x = val;
         CSR_FOCAL_Y:     fc_y = val;
         CSR_CENTER_U:    ct_u = val;
         CSR_CENTER_V:    ct_v = val;
         CSR_MAX_FORWARD: max_fwd = val[14:0];
         default: ;
      endcase
   endtask

   // one beat on the request side, with a random gap first; valid stays up
   // after the accepting edge until the next beat or a gap replaces it
   task automatic send_point(input logic signed [CW-1:0] x, y, z);
      int gap;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
            ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_point_x <= x; req_point_y <= y; req_point_z <= z;
      pixel_queue.push_back(project_point(x, y, z));
      do @(posedge clock); while (!req_ready);
   endtask

   // let everything drain before touching registers
   task automatic drain();
      req_valid <= 0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // receiver: random stalls, plus the long hold-off when requested
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_ready <= ($urandom_range(0, 29) == 0) ? 1'b0 : ($urandom_range(0, 1) == 0);
      end else begin
         rsp_ready <= 1;
      end
   end

   // checker: compare each beat with the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            report("unexpected beat", 1, 0);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_accepted !== want.accepted) report("accepted", rsp_accepted, want.accepted);
            if (rsp_pixel_u !== want.pixel_u) report("pixel_u", rsp_pixel_u, want.pixel_u);
            if (rsp_pixel_v !== want.pixel_v) report("pixel_v", rsp_pixel_v, want.pixel_v);
            if (rsp_red !== want.red) report("red", rsp_red, want.red);
            if (rsp_green !== want.green) report("green", rsp_green, want.green);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // random point: mostly inside the filters, some noise
   task automatic random_point();
      logic signed [CW-1:0] x, y, z;
      if ($urandom_range(0, 4) == 0) begin
         x = CW'($urandom); y = CW'($urandom); z = CW'($urandom);
      end else begin
         x = CW'($urandom_range(0, 26000));
         y = $signed(16'($urandom_range(0, 12300))) - 16'sd6150;
         z = $signed(16'($urandom_range(0, 9000))) - 16'sd1440;
      end
      send_point(x, y, z);
   endtask

   row_type table_rows[$];

   function automatic row_type mk(int x, int y, int z, logic known, pixel_type r);
      row_type t;
      t.x = CW'(x); t.y = CW'(y); t.z = CW'(z); t.known = known; t.res = r;
      return t;
   endfunction

   initial begin
      row_type t;
      pixel_type rej, p;
      rej = '0;
      // rejects are read off directly; everything else goes through the projector
      table_rows.push_back(mk(-1, 0, 0, 1, rej));                 // behind sensor
      table_rows.push_back(mk(-32768, 0, 0, 1, rej));
      table_rows.push_back(mk(25601, 0, 0, 1, rej));              // beyond max forward
      table_rows.push_back(mk(32767, 32767, 32767, 1, rej));
      table_rows.push_back(mk(5000, 6145, 0, 1, rej));            // too far left
      table_rows.push_back(mk(5000, -6145, 0, 1, rej));           // too far right
      table_rows.push_back(mk(5000, -32768, 0, 1, rej));
      table_rows.push_back(mk(5000, 0, -1434, 1, rej));           // too low
      table_rows.push_back(mk(5000, 0, -32768, 1, rej));
      table_rows.push_back(mk(203, 0, 0, 1, rej));                // depth zero
      table_rows.push_back(mk(0, 0, 0, 1, rej));                  // depth negative
      table_rows.push_back(mk(25600, 0, 0, 0, rej));
      table_rows.push_back(mk(10240, 0, 0, 0, rej));              // green full
      table_rows.push_back(mk(204, 0, 0, 0, rej));                // tiny depth, saturates
      table_rows.push_back(mk(204, 6144, -1433, 0, rej));
      table_rows.push_back(mk(204, -6144, 32767, 0, rej));
      table_rows.push_back(mk(20480, 6144, 0, 0, rej));           // green clamps
      table_rows.push_back(mk(1000, -6144, -1433, 0, rej));
      table_rows.push_back(mk(3000, 100, 32767, 0, rej));

      setup_reset();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         t = table_rows[i];
         send_point(t.x, t.y, t.z);
         if (t.known) pixel_queue[pixel_queue.size() - 1] = t.res;
      end
      drain();

      // settings: extremes first, then random ones, then the reset values again
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) begin
            write_reg(CSR_SHIFT_X, 16'h1000); write_reg(CSR_SHIFT_Y, 16'h1000);
            write_reg(CSR_SHIFT_Z, 16'h1000); write_reg(CSR_FOCAL_X, 16'hFFFF);
            write_reg(CSR_FOCAL_Y, 16'hFFFF); write_reg(CSR_CENTER_U, 16'h0000);
            write_reg(CSR_CENTER_V, 16'hFFFF); write_reg(CSR_MAX_FORWARD, 16'h7FFF);
         end else if (phase == 1) begin
            write_reg(CSR_SHIFT_X, 16'h0FFF); write_reg(CSR_SHIFT_Y, 16'h0FFF);
            write_reg(CSR_SHIFT_Z, 16'h0FFF); write_reg(CSR_FOCAL_X, 16'h0000);
            write_reg(CSR_FOCAL_Y, 16'h0000); write_reg(CSR_CENTER_U, 16'hFFFF);
            write_reg(CSR_CENTER_V, 16'h0000); write_reg(CSR_MAX_FORWARD, 16'h0000);
         end else if (phase == 5) begin
            write_reg(CSR_SHIFT_X, 16'($signed(-203))); write_reg(CSR_SHIFT_Y, 16'd41);
            write_reg(CSR_SHIFT_Z, 16'd166); write_reg(CSR_FOCAL_X, 16'd11515);
            write_reg(CSR_FOCAL_Y, 16'd11570); write_reg(CSR_CENTER_U, 16'd5379);
            write_reg(CSR_CENTER_V, 16'd3452); write_reg(CSR_MAX_FORWARD, 16'd25600);
         end else begin
            for (int r = 0; r < 8; r++) write_reg(CSR_IDX_W'(r), 16'($urandom));
         end
         for (int n = 0; n < 200; n++) begin
            // long receiver stall while points keep coming
            if (n == 50) hold_off = 80;
            random_point();
         end
         drain();
      end

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lpp_pkg.sv
rtl/lpp_front.sv
rtl/lpp_div_cell.sv
rtl/lidar_point_to_pixel_projection_unit.sv
tb/tb_lidar_point_to_pixel_projection_unit.sv
